>>> hdl/ptmw_pkg.sv
`timescale 1ns / 1ps

package ptmw_pkg;

    localparam int TABLE_PAGES_DEF = 16;

    localparam int ENTRY_W    = 64;
    localparam int IDX_W      = 9;
    localparam int PAGE_SHIFT = 12;
    localparam int FRAME_W    = 40;
    localparam int VA_W       = 48;
    localparam int PA_W       = 52;
    localparam int OP_W       = 3;
    localparam int STAT_W     = 3;

    localparam int IN_DATA_W  = 144;
    localparam int OUT_DATA_W = 56;

    localparam logic [OP_W-1:0] OP_MAP          = 3'd0;
    localparam logic [OP_W-1:0] OP_MAP_WC       = 3'd1;
    localparam logic [OP_W-1:0] OP_MAP_MMIO     = 3'd2;
    localparam logic [OP_W-1:0] OP_MAP_USER     = 3'd3;
    localparam logic [OP_W-1:0] OP_MAP_USER_WC  = 3'd4;
    localparam logic [OP_W-1:0] OP_UNMAP        = 3'd5;
    localparam logic [OP_W-1:0] OP_TRANSLATE    = 3'd6;
    localparam logic [OP_W-1:0] OP_NEW_ROOT     = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_MISALIGNED = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_MAPPED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EXHAUSTED  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_OUTSIDE    = 3'd4;

    localparam int E_PRESENT = 0;
    localparam int E_USER    = 2;

endpackage

>>> hdl/page_table_map_walk_engine.sv
`timescale 1ns / 1ps
// Four-level page-table walk engine over a private pool of table pages.
// Input stream (s_*): one command per transaction, opcode on s_tuser, root
// frame, virtual and physical address on s_tdata. Output stream (m_*): one
// response per command with status, result address and a TLB invalidate flag.
// pool_base_frame is written through the cfg_* channel only while the engine
// idles; the user must keep to this, the block itself does not enforce it. All
// table accesses go through one single-port table RAM with registered read data;
// each level passes through a read state and an evaluate state (with any write).
// Every new table taken (new root included) is cleared entry by entry. One
// command is walked at a time; s_tready is high only between commands. After
// reset the engine sweeps the whole table RAM to zero with s_tready low; cfg
// writes are taken. A finished response waits in the output register while
// m_tready is low and the next command is still taken; a second response then
// waits until the first transaction completes.
module page_table_map_walk_engine #(
    parameter int TABLE_PAGES = ptmw_pkg::TABLE_PAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ptmw_pkg::FRAME_W-1:0]    cfg_data,   // pool_base_frame
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptmw_pkg::IN_DATA_W-1:0]  s_tdata,    // root_frame, virt_addr, phys_addr
    input  logic [ptmw_pkg::OP_W-1:0]       s_tuser,    // opcode
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptmw_pkg::OUT_DATA_W-1:0] m_tdata     // status, result_addr, tlb_invalidate
);
    import ptmw_pkg::*;

    localparam int PAGE_W   = $clog2(TABLE_PAGES);
    localparam int NF_W     = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W   = PAGE_W + IDX_W;
    localparam int DEPTH    = TABLE_PAGES * (2 ** IDX_W);
    localparam logic [ADDR_W-1:0]  LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0]   LAST_IDX   = {IDX_W{1'b1}};
    localparam logic [NF_W-1:0]    POOL_PAGES = NF_W'(TABLE_PAGES);
    localparam logic [FRAME_W-1:0] POOL_LIMIT = FRAME_W'(TABLE_PAGES);

    localparam logic [2:0] S_CLR_ALL  = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_ROOT     = 3'd2;
    localparam logic [2:0] S_RD       = 3'd3;
    localparam logic [2:0] S_EVAL     = 3'd4;
    localparam logic [2:0] S_CLR_PAGE = 3'd5;
    localparam logic [2:0] S_NEW_ROOT = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [FRAME_W-1:0]  root_reg, root_next;
    logic [VA_W-1:0]     virt_reg, virt_next;
    logic [PA_W-1:0]     phys_reg, phys_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [1:0]          level_reg, level_next;
    logic [NF_W-1:0]     nf_reg, nf_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [STAT_W-1:0]   stat_reg, stat_next;
    logic [PA_W-1:0]     res_reg, res_next;
    logic                inval_reg, inval_next;
    logic [FRAME_W-1:0]  base_reg, base_next;
    logic [ADDR_W-1:0]   link_addr_reg, link_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]   out_stat_reg, out_stat_next;
    logic [PA_W-1:0]     out_res_reg, out_res_next;
    logic                out_inval_reg, out_inval_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [ENTRY_W-1:0]  rd;

    logic [OP_W-1:0]     in_op;
    logic [FRAME_W-1:0]  in_root;
    logic [VA_W-1:0]     in_virt;
    logic [PA_W-1:0]     in_phys;
    logic                in_is_map;

    logic                is_map, is_user, leaf_pwt, leaf_pcd;
    logic [IDX_W-1:0]    va_idx;
    logic [ADDR_W-1:0]   walk_addr;
    logic [FRAME_W-1:0]  frame_in, pool_off, new_frame;
    logic                in_pool, pool_full;
    logic [ENTRY_W-1:0]  new_entry, leaf_entry, link_entry;

    ptmw_table_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (rd)
    );

    assign in_op   = s_tuser;
    assign in_root = s_tdata[FRAME_W-1:0];
    assign in_virt = s_tdata[FRAME_W +: VA_W];
    assign in_phys = s_tdata[FRAME_W + VA_W +: PA_W];
    assign in_is_map = (in_op <= OP_MAP_USER_WC);

    assign is_map   = (op_reg <= OP_MAP_USER_WC);
    assign is_user  = (op_reg == OP_MAP_USER) || (op_reg == OP_MAP_USER_WC);
    assign leaf_pwt = (op_reg == OP_MAP_WC) || (op_reg == OP_MAP_MMIO)
                   || (op_reg == OP_MAP_USER_WC);
    assign leaf_pcd = (op_reg == OP_MAP_MMIO);

    always_comb
    begin
        case (level_reg)
            2'd3:    va_idx = virt_reg[47:39];
            2'd2:    va_idx = virt_reg[38:30];
            2'd1:    va_idx = virt_reg[29:21];
            default: va_idx = virt_reg[20:12];
        endcase
    end

    assign walk_addr = {page_reg, va_idx};

    // Shared frame-to-pool-page unit: root in S_ROOT, entry frame otherwise
    assign frame_in  = (state_reg == S_ROOT) ? root_reg : rd[PA_W-1:PAGE_SHIFT];
    assign pool_off  = frame_in - base_reg;
    assign in_pool   = (pool_off < POOL_LIMIT);
    assign pool_full = (nf_reg >= POOL_PAGES);
    assign new_frame = base_reg + FRAME_W'(nf_reg);

    assign new_entry  = {12'd0, new_frame, 9'd0, is_user, 1'b1, 1'b1};
    assign link_entry = {12'd0, base_reg + FRAME_W'(page_reg), 9'd0, is_user, 1'b1, 1'b1};
    assign leaf_entry = {rd[63:52], phys_reg[PA_W-1:PAGE_SHIFT], rd[11:5],
                         rd[4] | leaf_pcd, rd[3] | leaf_pwt, rd[2] | is_user,
                         1'b1, 1'b1};

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_inval_reg, out_res_reg, out_stat_reg};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        root_next      = root_reg;
        virt_next      = virt_reg;
        phys_next      = phys_reg;
        page_next      = page_reg;
        level_next     = level_reg;
        nf_next        = nf_reg;
        cnt_next       = cnt_reg;
        stat_next      = stat_reg;
        res_next       = res_reg;
        inval_next     = inval_reg;
        base_next      = base_reg;
        link_addr_next = link_addr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_stat_next  = out_stat_reg;
        out_res_next   = out_res_reg;
        out_inval_next = out_inval_reg;
        ram_we         = 1'b0;
        ram_addr       = walk_addr;
        ram_wdata      = '0;

        if (cfg_valid)
        begin
            base_next = cfg_data;
        end

        case (state_reg)
            S_CLR_ALL:
            begin
                ram_we   = 1'b1;
                ram_addr = cnt_reg;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = in_op;
                    root_next  = in_root;
                    virt_next  = in_virt;
                    phys_next  = in_phys;
                    stat_next  = STAT_OK;
                    res_next   = '0;
                    inval_next = 1'b0;
                    if (in_op == OP_NEW_ROOT)
                    begin
                        state_next = S_NEW_ROOT;
                    end
                    else if (in_is_map && ((in_virt[11:0] != 12'd0)
                                           || (in_phys[11:0] != 12'd0)))
                    begin
                        stat_next  = STAT_MISALIGNED;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_ROOT;
                    end
                end
            end

            S_NEW_ROOT:
            begin
                if (pool_full)
                begin
                    stat_next  = STAT_EXHAUSTED;
                    state_next = S_DONE;
                end
                else
                begin
                    res_next   = {new_frame, 12'd0};
                    page_next  = nf_reg[PAGE_W-1:0];
                    nf_next    = nf_reg + 1'b1;
                    cnt_next   = '0;
                    state_next = S_CLR_PAGE;
                end
            end

            S_ROOT:
            begin
                if (!in_pool)
                begin
                    stat_next  = STAT_OUTSIDE;
                    state_next = S_DONE;
                end
                else
                begin
                    page_next  = pool_off[PAGE_W-1:0];
                    level_next = 2'd3;
                    state_next = S_RD;
                end
            end

            S_RD:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                if (level_reg != 2'd0)
                begin
                    if (!rd[E_PRESENT])
                    begin
                        if (!is_map)
                        begin
                            stat_next  = STAT_NOT_MAPPED;
                            state_next = S_DONE;
                        end
                        else if (pool_full)
                        begin
                            stat_next  = STAT_EXHAUSTED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            // link a fresh table, then wipe it
                            ram_we         = 1'b1;
                            ram_wdata      = new_entry;
                            link_addr_next = walk_addr;
                            page_next      = nf_reg[PAGE_W-1:0];
                            nf_next        = nf_reg + 1'b1;
                            level_next     = level_reg - 1'b1;
                            cnt_next       = '0;
                            state_next     = S_CLR_PAGE;
                        end
                    end
                    else
                    begin
                        if (is_user)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = rd | (ENTRY_W'(1) << E_USER);
                        end
                        if (!in_pool)
                        begin
                            stat_next  = STAT_OUTSIDE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            page_next  = pool_off[PAGE_W-1:0];
                            level_next = level_reg - 1'b1;
                            state_next = S_RD;
                        end
                    end
                end
                else
                begin
                    state_next = S_DONE;
                    if (is_map)
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = leaf_entry;
                    end
                    else if (!rd[E_PRESENT])
                    begin
                        stat_next = STAT_NOT_MAPPED;
                    end
                    else if (op_reg == OP_UNMAP)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = '0;
                        inval_next = 1'b1;
                    end
                    else
                    begin
                        res_next = {rd[PA_W-1:PAGE_SHIFT], 12'd0};
                    end
                end
            end

            S_CLR_PAGE:
            begin
                ram_we   = 1'b1;
                ram_addr = {page_reg, cnt_reg[IDX_W-1:0]};
                // keep the link when the fresh table holds its own parent entry
                if (is_map && ({page_reg, cnt_reg[IDX_W-1:0]} == link_addr_reg))
                begin
                    ram_wdata = link_entry;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[IDX_W-1:0] == LAST_IDX)
                begin
                    state_next = (op_reg == OP_NEW_ROOT) ? S_DONE : S_RD;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    out_res_next   = res_reg;
                    out_inval_next = inval_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR_ALL;
            cnt_reg       <= '0;
            nf_reg        <= NF_W'(1);
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            nf_reg        <= nf_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        root_reg      <= root_next;
        virt_reg      <= virt_next;
        phys_reg      <= phys_next;
        page_reg      <= page_next;
        level_reg     <= level_next;
        stat_reg      <= stat_next;
        res_reg       <= res_next;
        inval_reg     <= inval_next;
        link_addr_reg <= link_addr_next;
        out_stat_reg  <= out_stat_next;
        out_res_reg   <= out_res_next;
        out_inval_reg <= out_inval_next;
    end

endmodule

>>> hdl/ptmw_table_ram.sv
`timescale 1ns / 1ps

module ptmw_table_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           addr,
    input  logic [ptmw_pkg::ENTRY_W-1:0] wdata,
    output logic [ptmw_pkg::ENTRY_W-1:0] rdata
);
    import ptmw_pkg::*;

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
